// ----- hw/rtl/moving_average_window_alarm_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the moving average window alarm
// Concurrent checks in simulation, empty bodies in synthesis.
// ---------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_WINDOW_ALARM_MACROS_SVH
`define MOVING_AVERAGE_WINDOW_ALARM_MACROS_SVH

`ifndef SYNTHESIS
// check with reset masking
`define MAWA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define MAWA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MAWA_ASSERT(lbl, clk, rst_n, prop, msg)
`define MAWA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/mawa_pkg.sv -----
// ---------------------------------------------------------------------------
// mawa_pkg
// Shared constants and types of the moving average window alarm.
// ---------------------------------------------------------------------------
package mawa_pkg;

	localparam int WINDOW    = 10;
	localparam int SAMPLE_W  = 16;
	localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W     = $clog2(WINDOW + 1);
	localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd1;

	localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RESET = 16'd4100;
	localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RESET  = 16'd3000;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} win_ctrl_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} win_stat_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- hw/rtl/moving_average_window_alarm.sv -----
// ---------------------------------------------------------------------------
// moving_average_window_alarm
// Boxcar average of battery voltage samples with a high/low window alarm.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/sample_mv) takes one word, a sample in
//   millivolts. Output channel (out_valid/out_ready) returns one word per
//   sample: the truncated average of the last WINDOW samples (fewer while the
//   ring fills) and out_of_range, set when the average lies above
//   high_limit_mv or below low_limit_mv.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   high limit at index 0 and the low limit at index 1; other indices drop.
//   Write it only while no sample is in flight. cfg_ready is always high.
// Steps:
//   From acceptance to out_valid a sample passes one sum update, the
//   iterations of the bit-serial divider, one step to take its done flag
//   and one to register the result. in_ready is low for the whole of
//   that time and rises with out_valid, so a new sample is taken only once
//   the last one is through.
// Reset and stall:
//   Reset empties the ring, zeroes the sum and fill count and loads the
//   limits with 4100 mV and 3000 mV. A finished word waits in the output
//   register while out_ready is low; a new sample is taken meanwhile, and its
//   result holds in the divider until the output register frees.
// ---------------------------------------------------------------------------
`include "moving_average_window_alarm_macros.svh"

module moving_average_window_alarm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mawa_pkg::SAMPLE_W-1:0]       sample_mv,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mawa_pkg::SAMPLE_W-1:0]       average_mv,
	output logic                                out_of_range,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mawa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mawa_pkg::SAMPLE_W-1:0]       cfg_data
);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;  // wait for a sample
	localparam logic [1:0] S_SUM  = 2'd1;  // oldest entry read, update sum and ring
	localparam logic [1:0] S_DIV  = 2'd2;  // divider iterating
	localparam logic [1:0] S_OUT  = 2'd3;  // quotient ready, wait for output register

	logic [1:0]                    state_q;
	logic [mawa_pkg::SAMPLE_W-1:0] sample_q;
	logic [mawa_pkg::SAMPLE_W-1:0] high_limit_q;
	logic [mawa_pkg::SAMPLE_W-1:0] low_limit_q;
	logic                          out_valid_q;
	logic [mawa_pkg::SAMPLE_W-1:0] average_q;
	logic                          alarm_q;

	mawa_pkg::win_ctrl_t           win_ctrl;
	mawa_pkg::win_stat_t           win_stat;
	mawa_pkg::div_req_t            div_req;
	mawa_pkg::div_rsp_t            div_rsp;

	logic                          in_acc;
	logic                          out_free;
	logic [mawa_pkg::SAMPLE_W-1:0] avg;
	logic                          alarm;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	// output register can take a word when empty or emptying now
	assign out_free  = !out_valid_q || out_ready;

	// the sum never exceeds WINDOW * 65535, so the average fits a word
	assign avg   = div_rsp.quotient[mawa_pkg::SAMPLE_W-1:0];
	assign alarm = (avg > high_limit_q) || (avg < low_limit_q);

	// read the oldest entry on acceptance, write the new sample in the cycle after
	assign win_ctrl.rd_en = in_acc;
	assign win_ctrl.wr_en = (state_q == S_SUM);

	assign div_req.start    = (state_q == S_SUM);
	assign div_req.dividend = win_stat.sum;
	assign div_req.divisor  = win_stat.count;

	mawa_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (win_ctrl),
		.sample (sample_q),
		.stat   (win_stat)
	);

	mawa_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_limit_q <= mawa_pkg::HIGH_LIMIT_RESET;
			low_limit_q  <= mawa_pkg::LOW_LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				mawa_pkg::REG_HIGH_LIMIT: high_limit_q <= cfg_data;
				mawa_pkg::REG_LOW_LIMIT:  low_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the sample for the ring write
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample_mv;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			average_q <= avg;
			alarm_q   <= alarm;
		end
	end

	assign out_valid    = out_valid_q;
	assign average_mv   = average_q;
	assign out_of_range = alarm_q;

	`MAWA_ASSERT(a_busy_after_accept, clk, arst_n, in_acc |=> !in_ready, "ready again right after a sample")
	`MAWA_ASSERT(a_done_in_div, clk, arst_n, div_rsp.done |-> (state_q == S_DIV), "divider finished outside the divide step")
	`MAWA_ASSERT(a_alarm_match, clk, arst_n, out_valid_q |-> (alarm_q == ((average_q > high_limit_q) || (average_q < low_limit_q))), "alarm disagrees with limits")

endmodule

// ----- hw/rtl/mawa_window.sv -----
// ---------------------------------------------------------------------------
// mawa_window
// Sample ring, oldest slot pointer, saturating fill count and running sum.
// ---------------------------------------------------------------------------
`include "moving_average_window_alarm_macros.svh"

module mawa_window (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mawa_pkg::win_ctrl_t                ctrl,
	input  logic [mawa_pkg::SAMPLE_W-1:0]      sample,
	output mawa_pkg::win_stat_t                stat
);

	logic [mawa_pkg::SAMPLE_W-1:0] ring_mem [mawa_pkg::WINDOW];
	logic [mawa_pkg::SAMPLE_W-1:0] rd_q;
	logic [mawa_pkg::SLOT_W-1:0]   slot_q;
	logic [mawa_pkg::CNT_W-1:0]    count_q;
	logic [mawa_pkg::SUM_W-1:0]    sum_q;
	logic                          full;
	logic [mawa_pkg::SAMPLE_W-1:0] oldest;

	// entries are written in slot order, so the slot ahead is unwritten until full
	assign full   = (count_q == mawa_pkg::CNT_W'(mawa_pkg::WINDOW));
	assign oldest = full ? rd_q : '0;

	assign stat.sum   = sum_q - mawa_pkg::SUM_W'(oldest) + mawa_pkg::SUM_W'(sample);
	assign stat.count = full ? count_q : count_q + mawa_pkg::CNT_W'(1);

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_q <= ring_mem[slot_q];
		end
		if (ctrl.wr_en) begin
			ring_mem[slot_q] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (ctrl.wr_en) begin
			sum_q   <= stat.sum;
			count_q <= stat.count;
			if (slot_q == mawa_pkg::SLOT_W'(mawa_pkg::WINDOW - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + mawa_pkg::SLOT_W'(1);
			end
		end
	end

	`MAWA_ASSERT(a_count_bound, clk, arst_n, count_q <= mawa_pkg::CNT_W'(mawa_pkg::WINDOW), "fill count beyond window")

endmodule

// ----- hw/rtl/mawa_divider.sv -----
// ---------------------------------------------------------------------------
// mawa_divider
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "moving_average_window_alarm_macros.svh"

module mawa_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  mawa_pkg::div_req_t req,
	output mawa_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [mawa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [mawa_pkg::SUM_W-1:0]     quo_q;
	logic [mawa_pkg::CNT_W-1:0]     rem_q;
	logic [mawa_pkg::CNT_W-1:0]     divisor_q;
	logic [mawa_pkg::CNT_W:0]       trial;
	logic [mawa_pkg::CNT_W:0]       rem_nx;
	logic                           ge;

	// shift in the next dividend bit, subtract when it fits
	assign trial  = {rem_q, quo_q[mawa_pkg::SUM_W-1]};
	assign ge     = (trial >= {1'b0, divisor_q});
	assign rem_nx = ge ? (trial - {1'b0, divisor_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= mawa_pkg::DIV_CNT_W'(mawa_pkg::SUM_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - mawa_pkg::DIV_CNT_W'(1);
			busy_q <= (cnt_q != mawa_pkg::DIV_CNT_W'(1));
			done_q <= (cnt_q == mawa_pkg::DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[mawa_pkg::SUM_W-2:0], ge};
			rem_q <= rem_nx[mawa_pkg::CNT_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`MAWA_ASSERT(a_done_pulse, clk, arst_n, done_q |=> !done_q, "divider done longer than one cycle")
	`MAWA_ASSERT(a_rem_bound, clk, arst_n, done_q |-> (rem_q < divisor_q), "remainder not below divisor")

endmodule

// ----- tb/tb_moving_average_window_alarm.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_moving_average_window_alarm
// Self-checking bench for the boxcar averager with its high/low alarm. A short
// table of directed words (cleared ring, full-scale samples, limits at their
// extremes, crossed limits, writes to unused register slots) is followed by
// random phases. Each phase writes new limits while the block is idle and then
// streams samples. Every accepted sample is folded into a local copy of the
// ring, sum and fill count. The expected average and alarm are queued and
// compared with each returned word. Both sides idle at random. One long
// receiver hold-off backs the block up until it stalls its input.
// ---------------------------------------------------------------------------
module tb_moving_average_window_alarm;

	// unused register slots: writes here must leave the limits alone
	localparam logic [mawa_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [mawa_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int PHASES         = 12;
	localparam int WORDS_PER_PHASE = 95;
	localparam int IDLE_PCT       = 27;
	localparam int HOLD_AT        = 400;  // results seen before the long hold-off
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 60;
	localparam int REPORT_LIMIT   = 10;

	typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;
	typedef enum logic [1:0] { MODE_UNIFORM, MODE_LEVEL, MODE_EXTREME } sample_mode_t;

	typedef struct packed {
		logic [mawa_pkg::SAMPLE_W-1:0] avg;
		logic                          alarm;
	} average_word_t;

	typedef struct {
		row_kind_t                      kind;
		logic [mawa_pkg::CFG_IDX_W-1:0] idx;
		logic [mawa_pkg::SAMPLE_W-1:0]  value;
		bit                             pinned;  // result typed in below rather than predicted
		average_word_t                  result;
	} directed_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic [mawa_pkg::SAMPLE_W-1:0]  sample_mv;
	logic                           out_valid;
	logic                           out_ready;
	logic [mawa_pkg::SAMPLE_W-1:0]  average_mv;
	logic                           out_of_range;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [mawa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mawa_pkg::SAMPLE_W-1:0]  cfg_data;

	// local copy of the block's window state and limits
	logic [mawa_pkg::SAMPLE_W-1:0] ring [mawa_pkg::WINDOW];
	logic [mawa_pkg::SLOT_W-1:0]   ring_slot;
	logic [mawa_pkg::CNT_W-1:0]    ring_fill;
	logic [mawa_pkg::SUM_W-1:0]    ring_sum;
	logic [mawa_pkg::SAMPLE_W-1:0] lim_high;
	logic [mawa_pkg::SAMPLE_W-1:0] lim_low;

	average_word_t pending_averages [$];

	int  mismatches;
	int  results_seen;
	int  alarms_seen;
	int  samples_sent;
	int  reg_writes;
	bit  steady;  // set while neither side may idle

	directed_row_t directed_rows [22];

	moving_average_window_alarm uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_mv    (sample_mv),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.average_mv   (average_mv),
		.out_of_range (out_of_range),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// Fold one sample into the window and return the word the block owes.
	function automatic average_word_t fold_in_sample(
		input logic [mawa_pkg::SAMPLE_W-1:0] s);
		average_word_t              w;
		logic [mawa_pkg::SUM_W-1:0] quot;
		// the oldest entry leaves the sum; a cleared slot contributes zero
		ring_sum = ring_sum - mawa_pkg::SUM_W'(ring[ring_slot]) + mawa_pkg::SUM_W'(s);
		ring[ring_slot] = s;
		ring_slot = (ring_slot == mawa_pkg::SLOT_W'(mawa_pkg::WINDOW - 1)) ?
		            '0 : ring_slot + 1'b1;
		if (ring_fill < mawa_pkg::CNT_W'(mawa_pkg::WINDOW))
			ring_fill = ring_fill + 1'b1;
		// divisor is at least one here, so the quotient is always defined
		quot = ring_sum / mawa_pkg::SUM_W'(ring_fill);
		w.avg = quot[mawa_pkg::SAMPLE_W-1:0];
		// strict comparisons on both sides, made as written even when crossed
		w.alarm = (w.avg > lim_high) || (w.avg < lim_low);
		return w;
	endfunction

	function automatic logic [mawa_pkg::SAMPLE_W-1:0] clamp_mv(input int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return mawa_pkg::SAMPLE_W'(v);
	endfunction

	function automatic logic [mawa_pkg::SAMPLE_W-1:0] draw_sample(input sample_mode_t mode,
	                                                              input int lvl);
		case (mode)
			MODE_LEVEL: begin
				// hover round the level so the average wanders across the limits
				return clamp_mv(lvl + $urandom_range(0, 400) - 200);
			end
			MODE_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return mawa_pkg::SAMPLE_W'(1) << $urandom_range(0, mawa_pkg::SAMPLE_W - 1);
					default: return mawa_pkg::SAMPLE_W'($urandom_range(0, 65535));
				endcase
			end
			default: return mawa_pkg::SAMPLE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Offer one sample word, with random idle cycles ahead of it, and queue its
	// expected result once the block takes it.
	task automatic offer_sample(input logic [mawa_pkg::SAMPLE_W-1:0] s, input bit pinned,
	                            input average_word_t pinned_word);
		average_word_t w;
		cfg_valid <= 1'b0;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_mv <= s;
		do @(posedge clk); while (!in_ready);
		w = fold_in_sample(s);
		pending_averages.push_back(pinned ? pinned_word : w);
		samples_sent++;
	endtask

	// Write one register once every owed word has come back.
	task automatic write_reg(input logic [mawa_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [mawa_pkg::SAMPLE_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			mawa_pkg::REG_HIGH_LIMIT: lim_high = data;
			mawa_pkg::REG_LOW_LIMIT:  lim_low  = data;
			default: ;  // unused slot: drop
		endcase
		reg_writes++;
	endtask

	// Receiver: random stalls, one stall-free stretch and one long hold-off.
	initial begin
		bit held;
		held      = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && results_seen >= HOLD_AT) begin
				// hold off while the sender keeps offering, so the block backs up
				held = 1'b1;
				out_ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Checker: compare every returned word with the oldest expectation.
	always @(posedge clk) begin
		average_word_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (out_of_range)
				alarms_seen++;
			if (pending_averages.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("ERROR: unexpected word average_mv=%0d out_of_range=%0b",
					         average_mv, out_of_range);
			end else begin
				want = pending_averages.pop_front();
				if (average_mv !== want.avg || out_of_range !== want.alarm) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"ERROR: word %0d average_mv exp %0d got %0d, ",
						          "out_of_range exp %0b got %0b"},
						         results_seen, want.avg, average_mv, want.alarm,
						         out_of_range);
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		sample_mode_t                  mode;
		int                            lvl;
		int                            spread;
		logic [mawa_pkg::SAMPLE_W-1:0] hi;
		logic [mawa_pkg::SAMPLE_W-1:0] lo;

		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample_mv    = '0;
		cfg_valid    = 1'b0;
		cfg_index    = mawa_pkg::REG_HIGH_LIMIT;
		cfg_data     = '0;
		steady       = 1'b0;
		mismatches   = 0;
		results_seen = 0;
		alarms_seen  = 0;
		samples_sent = 0;
		reg_writes   = 0;
		for (int i = 0; i < mawa_pkg::WINDOW; i++)
			ring[i] = '0;
		ring_slot = '0;
		ring_fill = '0;
		ring_sum  = '0;
		lim_high  = mawa_pkg::HIGH_LIMIT_RESET;
		lim_low   = mawa_pkg::LOW_LIMIT_RESET;

		// Directed words, reset limits 4100 / 3000 mV to start with.
		directed_rows = '{
			// first word after reset: the average is the sample itself
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'd0,     1'b1, '{16'd0,     1'b1}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b1, '{16'd32767, 1'b1}},
			// fill the rest of the ring with full scale
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
			// the zero drops out: ring all full scale, widest sum
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b1, '{16'hFFFF, 1'b1}},
			// an average equal to the high limit is not above it
			'{ROW_WRITE,  mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b1, '{16'hFFFF, 1'b0}},
			// nor is one equal to the low limit below it
			'{ROW_WRITE,  mawa_pkg::REG_LOW_LIMIT,  16'hFFFF,  1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'hFFFF,  1'b1, '{16'hFFFF, 1'b0}},
			// unused slots must leave both limits as they are
			'{ROW_WRITE,  REG_SPARE_2,              16'h0000,  1'b0, '{16'd0, 1'b0}},
			'{ROW_WRITE,  REG_SPARE_3,              16'h0000,  1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'd0,     1'b0, '{16'd0, 1'b0}},
			// crossed limits, low above high
			'{ROW_WRITE,  mawa_pkg::REG_HIGH_LIMIT, 16'd30000, 1'b0, '{16'd0, 1'b0}},
			'{ROW_WRITE,  mawa_pkg::REG_LOW_LIMIT,  16'd60000, 1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'd0,     1'b0, '{16'd0, 1'b0}},
			'{ROW_SAMPLE, mawa_pkg::REG_HIGH_LIMIT, 16'd20000, 1'b0, '{16'd0, 1'b0}}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE)
				write_reg(directed_rows[i].idx, directed_rows[i].value);
			else
				offer_sample(directed_rows[i].value, directed_rows[i].pinned,
				             directed_rows[i].result);
		end

		// Random phases: new limits while idle, then a stream of samples.
		for (int phase = 0; phase < PHASES; phase++) begin
			lvl    = $urandom_range(0, 65535);
			spread = $urandom_range(0, 300);
			case (phase)
				0: begin hi = '1; lo = '0; end  // window wide open
				1: begin hi = '0; lo = '1; end  // fully crossed
				default: begin
					case ($urandom_range(0, 4))
						0, 1: begin
							// narrow window round the level the samples hover at
							hi = clamp_mv(lvl + spread);
							lo = clamp_mv(lvl - spread);
						end
						2: begin
							hi = mawa_pkg::SAMPLE_W'(lvl);
							lo = mawa_pkg::SAMPLE_W'(lvl);
						end
						3: begin
							// crossed round the level
							hi = clamp_mv(lvl - spread);
							lo = clamp_mv(lvl + spread);
						end
						default: begin
							hi = mawa_pkg::SAMPLE_W'($urandom_range(0, 65535));
							lo = mawa_pkg::SAMPLE_W'($urandom_range(0, 65535));
						end
					endcase
				end
			endcase
			write_reg(mawa_pkg::REG_HIGH_LIMIT, hi);
			write_reg(mawa_pkg::REG_LOW_LIMIT, lo);
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
				          mawa_pkg::SAMPLE_W'($urandom_range(0, 65535)));

			case (phase % 4)
				0: mode = MODE_EXTREME;
				1: mode = MODE_UNIFORM;
				default: mode = MODE_LEVEL;
			endcase
			steady = (phase == 2);
			for (int k = 0; k < WORDS_PER_PHASE; k++)
				offer_sample(draw_sample(mode, lvl), 1'b0, '0);
			steady = 1'b0;
		end

		// Drain: wait for every owed word, then a little longer for strays.
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d samples and %0d register writes; %0d averages checked,",
		         samples_sent, reg_writes, results_seen);
		$display("%0d with the alarm raised; limits swept open, shut, crossed and round",
		         alarms_seen);
		$display("the signal level, with one long output hold-off.");
		if (mismatches == 0 && pending_averages.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mawa_pkg.sv
hw/rtl/mawa_window.sv
hw/rtl/mawa_divider.sv
hw/rtl/moving_average_window_alarm.sv
tb/tb_moving_average_window_alarm.sv
